### design/bsort_pkg.sv
package bsort_pkg;

    // Capacity of the cell row and the width of one stored value.
    localparam int NUM_CELLS  = 1024;
    localparam int VALUE_W    = 17;
    localparam int CELL_IDX_W = $clog2(NUM_CELLS);
    localparam int COUNT_W    = $clog2(NUM_CELLS + 1);

    // Configuration register widths, reset values and register indexes.
    localparam int LIMIT_W  = 18;
    localparam int BUCKET_W = 11;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(100000);
    localparam logic [BUCKET_W-1:0] BUCKET_RESET = BUCKET_W'(1000);
    localparam logic REG_VALUE_LIMIT  = 1'b0;
    localparam logic REG_BUCKET_COUNT = 1'b1;

    // Stream item modes.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Command broadcast from the controller to every cell in the row.
    typedef struct packed {
        logic               insert;
        logic               pop;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] fill;
    } chain_cmd_t;

endpackage

### design/bsort_cell.sv
module bsort_cell (
    input  logic                               clk,
    input  bsort_pkg::chain_cmd_t              cmd,
    input  logic [bsort_pkg::CELL_IDX_W-1:0]   idx,
    input  logic [bsort_pkg::VALUE_W-1:0]      left_val,
    input  logic                               left_gt,
    input  logic [bsort_pkg::VALUE_W-1:0]      right_val,
    output logic [bsort_pkg::VALUE_W-1:0]      val,
    output logic                               gt
);

    logic [bsort_pkg::VALUE_W-1:0] val_reg;
    logic [bsort_pkg::VALUE_W-1:0] val_next;
    logic                          occupied;

    // A cell is occupied when it lies below the fill level of the row.
    assign occupied = ({1'b0, idx} < cmd.fill);

    // The new value belongs at or before this cell when the cell is empty
    // or holds a strictly larger value, so equal values keep arrival order.
    assign gt = !occupied || (cmd.value < val_reg);

    // Insert shifts the tail of the row right by one; pop shifts it left.
    always_comb
    begin
        val_next = val_reg;
        if (cmd.insert)
        begin
            if (gt)
            begin
                val_next = left_gt ? left_val : cmd.value;
            end
        end
        else if (cmd.pop)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

### design/bsort_chain.sv
module bsort_chain (
    input  logic                          clk,
    input  bsort_pkg::chain_cmd_t         cmd,
    output logic [bsort_pkg::VALUE_W-1:0] head_val
);

    logic [bsort_pkg::VALUE_W-1:0] val_w [bsort_pkg::NUM_CELLS];
    logic                          gt_w  [bsort_pkg::NUM_CELLS];

    // Row of cells; each one sees its left and right neighbor only.
    for (genvar g = 0; g < bsort_pkg::NUM_CELLS; g++)
    begin : g_cell
        logic [bsort_pkg::VALUE_W-1:0] left_val;
        logic                          left_gt;
        logic [bsort_pkg::VALUE_W-1:0] right_val;

        if (g == 0)
        begin : g_first
            assign left_val = '0;
            assign left_gt  = 1'b0;
        end
        else
        begin : g_inner_left
            assign left_val = val_w[g-1];
            assign left_gt  = gt_w[g-1];
        end

        if (g == bsort_pkg::NUM_CELLS - 1)
        begin : g_last
            assign right_val = '0;
        end
        else
        begin : g_inner_right
            assign right_val = val_w[g+1];
        end

        bsort_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .idx       (bsort_pkg::CELL_IDX_W'(g)),
            .left_val  (left_val),
            .left_gt   (left_gt),
            .right_val (right_val),
            .val       (val_w[g]),
            .gt        (gt_w[g])
        );
    end

    // The smallest stored value always sits in the first cell.
    assign head_val = val_w[0];

endmodule

### design/bucket_sorter_unit.sv
// Sorting engine that collects up to 1024 unsigned 17-bit values and returns
// them in ascending order. A request with tuser set to 0 loads a value; the
// first load after any read starts a new set. A request with tuser set to 1
// returns the next smallest value, with tlast on the final one and an empty
// flag once the set is used up. Loads beyond capacity are dropped and flagged
// for the rest of the set. Values are kept sorted as they arrive in a row of
// compare-and-shift cells, so the unit accepts one request per clock while the
// result stream is not stalled, and a read result appears in the output register
// on the cycle after its request. The value_limit and bucket_count registers do
// not affect the order of the results; they are only stored and read back
// through the configuration port.
module bucket_sorter_unit (
    input  logic        clk,
    input  logic        rst_n,

    // Request stream. s_tdata: [16:0] value. s_tuser: [0] mode.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [0:0]  s_tuser,

    // Result stream. m_tdata: [16:0] sorted_value. m_tlast: is_last.
    // m_tuser: [0] empty_res, [1] overflowed.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tlast,
    output logic [1:0]  m_tuser,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int VW = bsort_pkg::VALUE_W;
    localparam int CW = bsort_pkg::COUNT_W;

    logic [bsort_pkg::LIMIT_W-1:0]  limit_reg;
    logic [bsort_pkg::BUCKET_W-1:0] buckets_reg;

    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic          reading_reg;
    logic          reading_next;
    logic          ovf_reg;
    logic          ovf_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [VW-1:0] out_value_reg;
    logic [VW-1:0] out_value_next;
    logic          out_last_reg;
    logic          out_last_next;
    logic          out_empty_reg;
    logic          out_empty_next;
    logic          out_ovf_reg;
    logic          out_ovf_next;

    logic                  accept;
    logic                  do_load;
    logic                  do_read;
    logic [CW-1:0]         base_fill;
    bsort_pkg::chain_cmd_t cmd;
    logic [VW-1:0]         head_val;
    logic                  cfg_write;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= bsort_pkg::LIMIT_RESET;
            buckets_reg <= bsort_pkg::BUCKET_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                bsort_pkg::REG_VALUE_LIMIT:  limit_reg   <= pwdata[bsort_pkg::LIMIT_W-1:0];
                bsort_pkg::REG_BUCKET_COUNT: buckets_reg <= pwdata[bsort_pkg::BUCKET_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            bsort_pkg::REG_VALUE_LIMIT:  prdata = 32'(limit_reg);
            bsort_pkg::REG_BUCKET_COUNT: prdata = 32'(buckets_reg);
            default:                     prdata = '0;
        endcase
    end

    // Request handshake; the output register frees itself as it drains.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign do_load  = accept && (s_tuser[0] == bsort_pkg::MODE_LOAD);
    assign do_read  = accept && (s_tuser[0] == bsort_pkg::MODE_READ);

    // A load after reading starts from an empty row.
    assign base_fill = reading_reg ? '0 : fill_reg;

    // Command to the cell row.
    always_comb
    begin
        cmd.insert = do_load && (base_fill < CW'(bsort_pkg::NUM_CELLS));
        cmd.pop    = do_read && (fill_reg != '0);
        cmd.value  = s_tdata[VW-1:0];
        cmd.fill   = base_fill;
    end

    bsort_chain u_chain (
        .clk      (clk),
        .cmd      (cmd),
        .head_val (head_val)
    );

    // Set bookkeeping: fill level, phase and overflow flag.
    always_comb
    begin
        fill_next    = fill_reg;
        reading_next = reading_reg;
        ovf_next     = ovf_reg;
        if (do_load)
        begin
            reading_next = 1'b0;
            if (reading_reg)
            begin
                ovf_next = 1'b0;
            end
            if (cmd.insert)
            begin
                fill_next = base_fill + CW'(1);
            end
            else
            begin
                fill_next = base_fill;
                ovf_next  = 1'b1;
            end
        end
        else if (do_read)
        begin
            reading_next = 1'b1;
            if (cmd.pop)
            begin
                fill_next = fill_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            reading_reg <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            fill_reg    <= fill_next;
            reading_reg <= reading_next;
            ovf_reg     <= ovf_next;
        end
    end

    // Output register for read results.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        out_ovf_next   = out_ovf_reg;
        if (do_read)
        begin
            out_valid_next = 1'b1;
            out_ovf_next   = ovf_reg;
            if (fill_reg != '0)
            begin
                out_value_next = head_val;
                out_last_next  = (fill_reg == CW'(1));
                out_empty_next = 1'b0;
            end
            else
            begin
                out_value_next = '0;
                out_last_next  = 1'b0;
                out_empty_next = 1'b1;
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 24'(out_value_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_ovf_reg, out_empty_reg};

endmodule

### tb/tb_bucket_sorter_unit.sv
module tb_bucket_sorter_unit;
    import bsort_pkg::*;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 20;

    // One read result, field by field.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               empty;
        logic               ovf;
    } sort_result_t;

    // One row of the directed stimulus; want is used only where typed is set.
    typedef struct packed {
        logic               mode;
        logic [VALUE_W-1:0] value;
        logic               typed;
        sort_result_t       want;
    } dir_row_t;

    localparam sort_result_t EMPTY_RESULT = '{value: '0, last: 1'b0, empty: 1'b1, ovf: 1'b0};

    // Empty reads after reset, extremes and duplicates, reads past the end, and
    // loads that start a new set while the previous one is still being read.
    localparam dir_row_t DIRECTED [22] = '{
        '{MODE_READ, VALUE_MAX,     1'b1, EMPTY_RESULT},
        '{MODE_READ, 17'd0,         1'b1, EMPTY_RESULT},
        '{MODE_LOAD, VALUE_MAX,     1'b0, EMPTY_RESULT},
        '{MODE_LOAD, 17'd0,         1'b0, EMPTY_RESULT},
        '{MODE_LOAD, 17'h10000,     1'b0, EMPTY_RESULT},
        '{MODE_LOAD, 17'd0,         1'b0, EMPTY_RESULT},
        '{MODE_LOAD, 17'd1,         1'b0, EMPTY_RESULT},
        '{MODE_READ, 17'h0AAAA,     1'b0, EMPTY_RESULT},
        '{MODE_READ, 17'h15555,     1'b0, EMPTY_RESULT},
        '{MODE_READ, 17'd0,         1'b0, EMPTY_RESULT},
        '{MODE_READ, VALUE_MAX,     1'b0, EMPTY_RESULT},
        '{MODE_READ, 17'd0,         1'b0, EMPTY_RESULT},
        '{MODE_READ, 17'd0,         1'b1, EMPTY_RESULT},
        '{MODE_LOAD, 17'd42,        1'b0, EMPTY_RESULT},
        '{MODE_READ, 17'd0,         1'b1, '{17'd42, 1'b1, 1'b0, 1'b0}},
        '{MODE_READ, 17'd0,         1'b1, EMPTY_RESULT},
        '{MODE_LOAD, 17'd7,         1'b0, EMPTY_RESULT},
        '{MODE_LOAD, 17'd3,         1'b0, EMPTY_RESULT},
        '{MODE_READ, 17'd0,         1'b0, EMPTY_RESULT},
        '{MODE_LOAD, 17'd9,         1'b0, EMPTY_RESULT},
        '{MODE_READ, 17'd0,         1'b1, '{17'd9, 1'b1, 1'b0, 1'b0}},
        '{MODE_READ, VALUE_MAX,     1'b1, EMPTY_RESULT}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bucket_sorter_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predictor state: the current set, kept in ascending order, and the
    // shadow copies of the two registers.
    logic [VALUE_W-1:0] set_values[$];
    int                 read_pos;
    bit                 reading;
    bit                 ovf_seen;
    logic [LIMIT_W-1:0]  limit_shadow;
    logic [BUCKET_W-1:0] bucket_shadow;

    sort_result_t pending_sorted[$];

    int src_idle_pct;
    int sink_idle_pct;
    int hold_requests;
    int hold_served;
    int hold_left;

    int fail_count;
    int loads_sent;
    int reads_sent;
    int results_seen;
    int sets_run;
    int config_settings;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Timeout guard.
    initial
    begin
        #1000000;
        $display("bucket_sorter_unit test failed");
        $finish;
    end

    // Works out the result of one accepted request. The value_limit and
    // bucket_count registers do not change the final ascending order, so
    // the set is simply kept sorted as values arrive.
    function automatic bit next_sorted_value(input logic mode, input logic [VALUE_W-1:0] value,
                                             output sort_result_t res);
        int idx;
        res = '0;
        if (mode == MODE_LOAD)
        begin
            if (reading)
            begin
                reading = 1'b0;
                set_values.delete();
                read_pos = 0;
                ovf_seen = 1'b0;
            end
            if (set_values.size() < NUM_CELLS)
            begin
                idx = 0;
                while (idx < set_values.size() && set_values[idx] <= value)
                    idx++;
                set_values.insert(idx, value);
            end
            else
                ovf_seen = 1'b1;
            return 1'b0;
        end
        if (!reading)
        begin
            reading = 1'b1;
            read_pos = 0;
        end
        if (read_pos < set_values.size())
        begin
            res.value = set_values[read_pos];
            res.last  = (read_pos + 1 == set_values.size());
            read_pos++;
        end
        else
            res.empty = 1'b1;
        res.ovf = ovf_seen;
        return 1'b1;
    endfunction

    // Offers one request and waits until it is accepted.
    task automatic send_request(input logic mode, input logic [VALUE_W-1:0] value,
                                input logic typed, input sort_result_t want);
        sort_result_t predicted;
        bit           has_result;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(24 - VALUE_W){1'b0}}, value};
        s_tuser  = mode;
        do @(posedge clk); while (!s_tready);
        has_result = next_sorted_value(mode, value, predicted);
        if (has_result)
            pending_sorted.push_back(typed ? want : predicted);
        if (mode == MODE_LOAD)
            loads_sent++;
        else
            reads_sent++;
    endtask

    // Drops the request stream and waits until the unit has gone idle.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_sorted.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register read with a check of the returned value.
    task automatic reg_check(input logic idx, input logic [31:0] want);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            $error("register %0d readback: expected %0d, actual %0d", idx, want, prdata);
            fail_count++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Register write; the shadow copy follows and the written register is read back.
    task automatic reg_write(input logic idx, input logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_VALUE_LIMIT)
            limit_shadow = data[LIMIT_W-1:0];
        else
            bucket_shadow = data[BUCKET_W-1:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        reg_check(idx, (idx == REG_VALUE_LIMIT) ? 32'(limit_shadow) : 32'(bucket_shadow));
    endtask

    function automatic logic [VALUE_W-1:0] pick_value(input int profile);
        case (profile)
            0: return VALUE_W'($urandom_range(VALUE_MAX));
            1: return VALUE_W'($urandom_range(15));
            2:
            begin
                case ($urandom_range(3))
                    0: return '0;
                    1: return VALUE_MAX;
                    2: return VALUE_W'(1);
                    default: return VALUE_MAX - 1'b1;
                endcase
            end
            default: return VALUE_W'($urandom_range(2000));
        endcase
    endfunction

    // One set: a run of loads followed by a run of reads.
    task automatic run_set(input int n_loads, input int n_reads);
        int profile;
        profile = $urandom_range(3);
        for (int i = 0; i < n_loads; i++)
            send_request(MODE_LOAD, pick_value(profile), 1'b0, '0);
        for (int i = 0; i < n_reads; i++)
            send_request(MODE_READ, VALUE_W'($urandom_range(VALUE_MAX)), 1'b0, '0);
        sets_run++;
    endtask

    // Result side: random back-pressure, with long hold-offs on request.
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready = 1'b0;
        end
        else
            m_tready = ($urandom_range(99) >= sink_idle_pct);
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        sort_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_sorted.size() == 0)
            begin
                $error("result with no request waiting: sorted_value %0d", m_tdata[VALUE_W-1:0]);
                fail_count++;
            end
            else
            begin
                want = pending_sorted.pop_front();
                if (m_tdata[VALUE_W-1:0] !== want.value)
                begin
                    $error("sorted_value: expected %0d, actual %0d",
                           want.value, m_tdata[VALUE_W-1:0]);
                    fail_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("is_last: expected %0d, actual %0d", want.last, m_tlast);
                    fail_count++;
                end
                if (m_tuser[0] !== want.empty)
                begin
                    $error("empty_res: expected %0d, actual %0d", want.empty, m_tuser[0]);
                    fail_count++;
                end
                if (m_tuser[1] !== want.ovf)
                begin
                    $error("overflowed: expected %0d, actual %0d", want.ovf, m_tuser[1]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int phase_items;
        int n_loads;
        int n_reads;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        set_values.delete();
        read_pos      = 0;
        reading       = 1'b0;
        ovf_seen      = 1'b0;
        limit_shadow  = LIMIT_RESET;
        bucket_shadow = BUCKET_RESET;
        src_idle_pct  = 20;
        sink_idle_pct = 49;
        hold_requests = 0;
        hold_served   = 0;
        hold_left     = 0;
        fail_count    = 0;
        loads_sent    = 0;
        reads_sent    = 0;
        results_seen  = 0;
        sets_run      = 0;
        config_settings = 1;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Registers come out of reset with their documented values.
        reg_check(REG_VALUE_LIMIT, 32'(LIMIT_RESET));
        reg_check(REG_BUCKET_COUNT, 32'(BUCKET_RESET));

        for (int i = 0; i < $size(DIRECTED); i++)
            send_request(DIRECTED[i].mode, DIRECTED[i].value, DIRECTED[i].typed,
                         DIRECTED[i].want);

        // Random phases, each under its own register setting and idle pattern.
        for (int phase = 0; phase < 6; phase++)
        begin
            src_idle_pct  = (phase < 2) ? 20 : (phase < 4) ? 49 : 0;
            sink_idle_pct = (phase < 2) ? 49 : (phase < 4) ? 20 : 0;
            if (phase > 0)
            begin
                // Registers change only while idle, often in the middle of a set.
                wait_idle();
                case (phase)
                    1:
                    begin
                        reg_write(REG_VALUE_LIMIT, 32'd1);
                        reg_write(REG_BUCKET_COUNT, 32'd1);
                    end
                    2:
                    begin
                        reg_write(REG_VALUE_LIMIT, 32'((1 << LIMIT_W) - 1));
                        reg_write(REG_BUCKET_COUNT, 32'((1 << BUCKET_W) - 1));
                    end
                    3:
                    begin
                        reg_write(REG_VALUE_LIMIT, 32'd0);
                        reg_write(REG_BUCKET_COUNT, 32'd0);
                    end
                    4:
                    begin
                        reg_write(REG_VALUE_LIMIT, 32'd131072);
                        reg_write(REG_BUCKET_COUNT, 32'd1024);
                    end
                    default:
                    begin
                        // Limit below the bucket count.
                        reg_write(REG_VALUE_LIMIT, 32'($urandom_range(1, 500)));
                        reg_write(REG_BUCKET_COUNT, 32'($urandom_range(501, 2047)));
                    end
                endcase
                config_settings++;
            end

            // A set larger than the capacity; its reads carry the overflow flag.
            if (phase == 2)
                run_set(NUM_CELLS + 4, 12);

            // Long result stall while reads keep arriving, so the input backs up.
            if (phase == 4)
            begin
                hold_requests++;
                run_set(20, 30);
            end

            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                n_loads = ($urandom_range(99) < 80) ? $urandom_range(1, 12)
                                                    : $urandom_range(13, 40);
                case ($urandom_range(9))
                    0, 1: n_reads = $urandom_range(0, n_loads);
                    2:    n_reads = n_loads + $urandom_range(1, 4);
                    default: n_reads = n_loads;
                endcase
                run_set(n_loads, n_reads);
                phase_items += n_loads + n_reads;
            end
        end

        wait_idle();

        $display("Ran %0d loads and %0d reads in %0d sets under %0d register settings,",
                 loads_sent, reads_sent, sets_run, config_settings);
        $display("including one set past capacity and a long result stall; %0d results checked.",
                 results_seen);
        if (fail_count == 0 && pending_sorted.size() == 0)
            $display("bucket_sorter_unit test passed");
        else
            $display("bucket_sorter_unit test failed");
        $finish;
    end

endmodule
